>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define MAG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/mag_pkg.sv
// ----------------------------------------------------------------------------
// mag_pkg: shared types and constants of the multi-ant grid walker
// result kinds, headings, register indexes and the microcode program
// ----------------------------------------------------------------------------
package mag_pkg;

  localparam int unsigned CFG_W     = 9;
  localparam int unsigned XY_W      = 8;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    KIND_ADDED    = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_UPDATE   = 2'd2
  } kind_e;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_e;

  // microcode step addresses
  typedef enum logic [2:0] {
    UPC_IDLE    = 3'd0,
    UPC_ADD     = 3'd1,
    UPC_ANT_RD  = 3'd2,
    UPC_WRAP    = 3'd3,
    UPC_GRID_RD = 3'd4,
    UPC_FLIP    = 3'd5
  } upc_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_DISPATCH = 2'd1,
    JMP_IDLE     = 2'd2,
    JMP_LOOP     = 2'd3
  } jmp_e;

  typedef struct packed {
    logic accept;
    logic wait_out;
    logic ant_rd;
    logic wrap_ld;
    logic grid_rd;
    logic emit_add;
    logic emit_upd;
    jmp_e jmp;
  } ucode_t;

  typedef struct packed {
    logic func_tick;
    logic no_ants;
    logic last_ant;
    logic out_free;
    logic grid_ready;
  } seq_stat_t;

  typedef struct packed {
    ucode_t cw;
    logic   fire;
  } seq_ctrl_t;

  function automatic ucode_t ucode_rom(upc_e pc);
    ucode_t w;
    w = '0;
    case (pc)
      UPC_IDLE: begin
        w.accept = 1'b1;
        w.jmp    = JMP_DISPATCH;
      end
      UPC_ADD: begin
        w.wait_out = 1'b1;
        w.emit_add = 1'b1;
        w.jmp      = JMP_IDLE;
      end
      UPC_ANT_RD: begin
        w.ant_rd = 1'b1;
        w.jmp    = JMP_NEXT;
      end
      UPC_WRAP: begin
        w.wrap_ld = 1'b1;
        w.jmp     = JMP_NEXT;
      end
      UPC_GRID_RD: begin
        w.grid_rd = 1'b1;
        w.jmp     = JMP_NEXT;
      end
      UPC_FLIP: begin
        w.wait_out = 1'b1;
        w.emit_upd = 1'b1;
        w.jmp      = JMP_LOOP;
      end
      default: begin
        w.jmp = JMP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic dir_e turn_left(dir_e d);
    dir_e r;
    case (d)
      DIR_NORTH: r = DIR_WEST;
      DIR_EAST:  r = DIR_NORTH;
      DIR_WEST:  r = DIR_SOUTH;
      DIR_SOUTH: r = DIR_EAST;
      default:   r = DIR_NORTH;
    endcase
    return r;
  endfunction

  function automatic dir_e turn_right(dir_e d);
    dir_e r;
    case (d)
      DIR_NORTH: r = DIR_EAST;
      DIR_EAST:  r = DIR_SOUTH;
      DIR_WEST:  r = DIR_NORTH;
      DIR_SOUTH: r = DIR_WEST;
      default:   r = DIR_NORTH;
    endcase
    return r;
  endfunction

endpackage

>>> src/mag_ants.sv
// ----------------------------------------------------------------------------
// mag_ants: ant table memory
// one write port and one registered read port, contents undefined until written
// ----------------------------------------------------------------------------
module mag_ants #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 22
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mag_grid.sv
// ----------------------------------------------------------------------------
// mag_grid: one-bit cell memory of the walker grid
// registered read, shared write port, clearing sweep after reset
// ----------------------------------------------------------------------------
module mag_grid #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic          wdata_i,
  input  logic          re_i,
  output logic          rdata_o,
  output logic          ready_o
);

  logic          mem_q [DEPTH];
  logic          rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  // sweep owns the write port until every cell is dead
  assign mem_we    = clr_busy_q || we_i;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : addr_i;
  assign mem_wdata = clr_busy_q ? 1'b0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

>>> src/mag_seq.sv
// ----------------------------------------------------------------------------
// mag_seq: microcode sequencer
// step counter over the control word program with conditional jumps
// ----------------------------------------------------------------------------
module mag_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mag_pkg::seq_stat_t  stat_i,
  output logic                in_ready_o,
  output mag_pkg::seq_ctrl_t  ctrl_o
);

  import mag_pkg::*;

  upc_e   upc_q, upc_d;
  ucode_t cw;
  logic   fire;

  always_comb begin
    cw         = ucode_rom(upc_q);
    in_ready_o = cw.accept && stat_i.grid_ready;
    if (cw.accept) begin
      fire = in_valid_i && stat_i.grid_ready;
    end else begin
      // result steps hold until the output register can take the result
      fire = !cw.wait_out || stat_i.out_free;
    end

    upc_d = upc_q;
    if (fire) begin
      case (cw.jmp)
        JMP_NEXT: upc_d = upc_e'(upc_q + 3'd1);
        JMP_DISPATCH: begin
          if (!stat_i.func_tick) begin
            upc_d = UPC_ADD;
          end else if (stat_i.no_ants) begin
            upc_d = UPC_IDLE;
          end else begin
            upc_d = UPC_ANT_RD;
          end
        end
        JMP_IDLE: upc_d = UPC_IDLE;
        JMP_LOOP: upc_d = stat_i.last_ant ? UPC_IDLE : UPC_ANT_RD;
        default:  upc_d = UPC_IDLE;
      endcase
    end

    ctrl_o.cw   = cw;
    ctrl_o.fire = fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> src/multi_ant_grid_walker_core.sv
// ----------------------------------------------------------------------------
// multi_ant_grid_walker_core: several turning ants on a wrapping one-bit grid
// add: taken in the idle step, result registered in the add step once the output is free
// tick: per stored ant the steps ant read, wrap, grid read and flip, one ant after another
// reset: grid clear sweep over all MAX_WIDTH*MAX_HEIGHT cells with in_ready_o low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_ant_grid_walker_core #(
  parameter int unsigned MAX_ANTS   = 16,
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [1:0] start_dir_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [3:0] ant_index_o,
  output logic [7:0] cell_x_o,
  output logic [7:0] cell_y_o,
  output logic       cell_alive_o,
  output logic [1:0] new_dir_o,
  output logic       last_o
);

  import mag_pkg::*;

  localparam int unsigned IW     = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int unsigned CNTW   = $clog2(MAX_ANTS + 1);
  localparam int unsigned IXW    = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned XSW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YSW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XMAX   = (MAX_WIDTH > 255) ? MAX_WIDTH : 255;
  localparam int unsigned YMAX   = (MAX_HEIGHT > 255) ? MAX_HEIGHT : 255;
  localparam int unsigned CW     = $clog2(XMAX + 1) + 1;
  localparam int unsigned RW     = $clog2(YMAX + 1) + 1;
  localparam int unsigned XCW    = (XSW > CFG_W) ? XSW : CFG_W;
  localparam int unsigned YCW    = (YSW > CFG_W) ? YSW : CFG_W;
  localparam int unsigned W_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned H_RST  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int unsigned GDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned GAW    = $clog2(GDEPTH);
  localparam int unsigned ADW    = CW + RW + DIR_W;

  // configuration, held clamped to the usable range
  logic [XSW-1:0] w_q;
  logic [YSW-1:0] h_q;
  logic [XSW-1:0] w_clamp;
  logic [YSW-1:0] h_clamp;
  logic [XCW-1:0] w_raw;
  logic [YCW-1:0] h_raw;
  logic           cfg_we;

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  logic [CNTW-1:0] count_q;
  logic [IW-1:0]   idx_q;
  logic [XY_W-1:0] sx_q, sy_q;
  dir_e            sd_q;
  logic [XW-1:0]   x_q;
  logic [YW-1:0]   y_q;
  dir_e            d_q;

  logic [ADW-1:0]  ant_rdata;
  logic            ant_we;
  logic [IW-1:0]   ant_waddr;
  logic [ADW-1:0]  ant_wdata;
  logic signed [CW-1:0] col_s, w_s;
  logic signed [RW-1:0] row_s, h_s;
  logic [XW-1:0]   x_wrap;
  logic [YW-1:0]   y_wrap;
  logic [CW-1:0]   col_new;
  logic [RW-1:0]   row_new;
  dir_e            d_new;

  logic [GAW-1:0]  gaddr;
  logic            g_old;
  logic            g_we;
  logic            grid_ready;

  logic            full;
  logic            last_ant;
  logic            out_free;
  logic            accept_fire, emit_add_fire, emit_upd_fire, emit;

  logic            out_valid_q;
  kind_e           out_kind_q;
  logic [3:0]      out_idx_q;
  logic [7:0]      out_x_q, out_y_q;
  logic            out_alive_q;
  dir_e            out_dir_q;
  logic            out_last_q;
  logic [IXW-1:0]  idx_wide, cnt_wide;
  logic [CW-1:0]   x_wide;
  logic [RW-1:0]   y_wide;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    w_raw = XCW'(cfg_data_i);
    h_raw = YCW'(cfg_data_i);
    if (w_raw == '0) begin
      w_clamp = XSW'(1);
    end else if (w_raw > XCW'(MAX_WIDTH)) begin
      w_clamp = XSW'(MAX_WIDTH);
    end else begin
      w_clamp = XSW'(w_raw);
    end
    if (h_raw == '0) begin
      h_clamp = YSW'(1);
    end else if (h_raw > YCW'(MAX_HEIGHT)) begin
      h_clamp = YSW'(MAX_HEIGHT);
    end else begin
      h_clamp = YSW'(h_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= XSW'(W_RST);
      h_q <= YSW'(H_RST);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  w_q <= w_clamp;
        REG_GRID_HEIGHT: h_q <= h_clamp;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign full     = (count_q == CNTW'(MAX_ANTS));
  assign last_ant = ((CNTW'(idx_q) + CNTW'(1)) == count_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat.func_tick  = (func_e'(func_i) == FUNC_TICK);
  assign stat.no_ants    = (count_q == '0);
  assign stat.last_ant   = last_ant;
  assign stat.out_free   = out_free;
  assign stat.grid_ready = grid_ready;

  mag_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  assign accept_fire   = ctrl.fire && ctrl.cw.accept;
  assign emit_add_fire = ctrl.fire && ctrl.cw.emit_add;
  assign emit_upd_fire = ctrl.fire && ctrl.cw.emit_upd;
  assign emit          = emit_add_fire || emit_upd_fire;

  // ---------------- ant table ----------------
  assign ant_we    = (emit_add_fire && !full) || emit_upd_fire;
  assign ant_waddr = emit_upd_fire ? idx_q : IW'(count_q);
  assign ant_wdata = emit_upd_fire ? {col_new, row_new, d_new}
                                   : {CW'(sx_q), RW'(sy_q), sd_q};

  mag_ants #(
    .DEPTH (MAX_ANTS),
    .AW    (IW),
    .DW    (ADW)
  ) u_ants (
    .clk_i   (clk_i),
    .we_i    (ant_we),
    .waddr_i (ant_waddr),
    .wdata_i (ant_wdata),
    .re_i    (ctrl.fire && ctrl.cw.ant_rd),
    .raddr_i (idx_q),
    .rdata_o (ant_rdata)
  );

  // wrap: at or past the size goes to 0, below 0 goes to size-1
  always_comb begin
    col_s = $signed(ant_rdata[ADW-1 -: CW]);
    row_s = $signed(ant_rdata[DIR_W +: RW]);
    w_s   = $signed(CW'(w_q));
    h_s   = $signed(RW'(h_q));
    if (col_s >= w_s) begin
      x_wrap = '0;
    end else if (col_s < 0) begin
      x_wrap = XW'(w_q - XSW'(1));
    end else begin
      x_wrap = XW'(col_s);
    end
    if (row_s >= h_s) begin
      y_wrap = '0;
    end else if (row_s < 0) begin
      y_wrap = YW'(h_q - YSW'(1));
    end else begin
      y_wrap = YW'(row_s);
    end
  end

  // ---------------- grid ----------------
  assign gaddr = GAW'(y_q) * GAW'(MAX_WIDTH) + GAW'(x_q);
  assign g_we  = emit_upd_fire;

  mag_grid #(
    .DEPTH (GDEPTH),
    .AW    (GAW)
  ) u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (gaddr),
    .we_i    (g_we),
    .wdata_i (!g_old),
    .re_i    (ctrl.fire && ctrl.cw.grid_rd),
    .rdata_o (g_old),
    .ready_o (grid_ready)
  );

  // live cell turns left, dead cell turns right, then one step
  always_comb begin
    d_new   = g_old ? turn_left(d_q) : turn_right(d_q);
    col_new = CW'(x_q);
    row_new = RW'(y_q);
    case (d_new)
      DIR_NORTH: row_new = RW'(y_q) - RW'(1);
      DIR_EAST:  col_new = CW'(x_q) + CW'(1);
      DIR_WEST:  col_new = CW'(x_q) - CW'(1);
      DIR_SOUTH: row_new = RW'(y_q) + RW'(1);
      default: ;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_add_fire && !full) begin
        count_q <= count_q + CNTW'(1);
      end
      if (accept_fire) begin
        idx_q <= '0;
      end else if (emit_upd_fire) begin
        idx_q <= idx_q + IW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_wide = IXW'(idx_q);
  assign cnt_wide = IXW'(count_q);
  assign x_wide   = CW'(x_q);
  assign y_wide   = RW'(y_q);

  always_ff @(posedge clk_i) begin
    if (accept_fire) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      sd_q <= dir_e'(start_dir_i);
    end
    if (ctrl.fire && ctrl.cw.wrap_ld) begin
      x_q <= x_wrap;
      y_q <= y_wrap;
      d_q <= dir_e'(ant_rdata[DIR_W-1:0]);
    end
    if (emit_add_fire) begin
      out_kind_q  <= full ? KIND_REJECTED : KIND_ADDED;
      out_idx_q   <= full ? '0 : cnt_wide[IDX_OUT_W-1:0];
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_alive_q <= 1'b0;
      out_dir_q   <= full ? DIR_NORTH : sd_q;
      out_last_q  <= 1'b1;
    end else if (emit_upd_fire) begin
      out_kind_q  <= KIND_UPDATE;
      out_idx_q   <= idx_wide[IDX_OUT_W-1:0];
      out_x_q     <= x_wide[XY_W-1:0];
      out_y_q     <= y_wide[XY_W-1:0];
      out_alive_q <= !g_old;
      out_dir_q   <= d_new;
      out_last_q  <= last_ant;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign ant_index_o  = out_idx_q;
  assign cell_x_o     = out_x_q;
  assign cell_y_o     = out_y_q;
  assign cell_alive_o = out_alive_q;
  assign new_dir_o    = out_dir_q;
  assign last_o       = out_last_q;

  // ---------------- assertions ----------------
  `MAG_ASSERT(a_accept_after_clear, (in_valid_i && in_ready_o) |-> grid_ready, "request taken during grid clear")
  `MAG_NEVER(a_result_overrun, emit && out_valid_q && !out_ready_i, "result overwrites a pending result")
  `MAG_NEVER(a_count_bound, count_q > CNTW'(MAX_ANTS), "ant count above table size")
  `MAG_ASSERT(a_count_step, emit_add_fire |=> (count_q == $past(count_q) + CNTW'(1)) || ($past(count_q) == CNTW'(MAX_ANTS)), "ant count did not advance on add")
  `MAG_NEVER(a_grid_write_clear, g_we && !grid_ready, "grid write during clear sweep")

endmodule

>>> test/multi_ant_grid_walker_core_tb.sv
// ----------------------------------------------------------------------------
// multi_ant_grid_walker_core_tb: self-checking bench of the multi-ant walker
// adds and ticks are driven over valid/ready while the bench keeps its own
// grid, ant table and size registers, and checks every result in order;
// grid sizes are reprogrammed between phases, both sides idle at random
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_ant_grid_walker_core_tb;
  import mag_pkg::*;

  localparam int ANT_SLOTS  = 16;
  localparam int GRID_MAX   = 256;
  localparam int STALL_MAX  = 8;
  localparam int IDLE_LIMIT = 300000;
  localparam int SETTLE_CYC = 20;
  localparam int DRAIN_CYC  = 150;
  localparam int REPORT_MAX = 10;

  // indexes that select no register
  localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] idx;
    logic [7:0] x;
    logic [7:0] y;
    logic       alive;
    dir_e       dir;
    logic       last;
  } ant_result_t;

  class walk_scoreboard;
    ant_result_t pending[$];
    bit          cells[GRID_MAX*GRID_MAX];
    int          ant_x[ANT_SLOTS];
    int          ant_y[ANT_SLOTS];
    dir_e        ant_dir[ANT_SLOTS];
    int          n_ants;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    int          n_errors;

    function new();
      width_reg  = 9'd256;
      height_reg = 9'd256;
    endfunction

    function int eff_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return int'(v);
    endfunction

    function int cols();
      return eff_size(width_reg);
    endfunction

    function int rows();
      return eff_size(height_reg);
    endfunction

    function void set_size(logic [REG_IDX_W-1:0] index, logic [8:0] data);
      if (index == REG_GRID_WIDTH) width_reg = data;
      else if (index == REG_GRID_HEIGHT) height_reg = data;
    endfunction

    // appends one expected result at the tail
    function void enqueue(ant_result_t r);
      pending = {pending, r};
    endfunction

    // no modulo: past the edge goes to 0, below 0 goes to the far edge
    function int wrap(int c, int size);
      if (c > size - 1) return 0;
      if (c < 0) return size - 1;
      return c;
    endfunction

    function dir_e turned(dir_e d, bit to_left);
      case (d)
        DIR_NORTH: return to_left ? DIR_WEST  : DIR_EAST;
        DIR_EAST:  return to_left ? DIR_NORTH : DIR_SOUTH;
        DIR_WEST:  return to_left ? DIR_SOUTH : DIR_NORTH;
        default:   return to_left ? DIR_EAST  : DIR_WEST;
      endcase
    endfunction

    function void note_request(func_e f, logic [7:0] sx, logic [7:0] sy, dir_e sd);
      ant_result_t r;
      int          x;
      int          y;
      bit          was;
      dir_e        d;
      if (f == FUNC_ADD) begin
        r = '0;
        r.last = 1'b1;
        if (n_ants >= ANT_SLOTS) begin
          r.kind = KIND_REJECTED;
        end else begin
          ant_x[n_ants]   = int'(sx);
          ant_y[n_ants]   = int'(sy);
          ant_dir[n_ants] = sd;
          r.kind = KIND_ADDED;
          r.idx  = 4'(n_ants);
          r.dir  = sd;
          n_ants++;
        end
        enqueue(r);
        return;
      end
      for (int i = 0; i < n_ants; i++) begin
        x   = wrap(ant_x[i], cols());
        y   = wrap(ant_y[i], rows());
        was = cells[y*GRID_MAX + x];
        cells[y*GRID_MAX + x] = !was;
        d = turned(ant_dir[i], was);
        r.kind  = KIND_UPDATE;
        r.idx   = 4'(i);
        r.x     = 8'(x);
        r.y     = 8'(y);
        r.alive = !was;
        r.dir   = d;
        r.last  = (i == n_ants - 1);
        enqueue(r);
        // north is toward row 0
        case (d)
          DIR_NORTH: y--;
          DIR_EAST:  x++;
          DIR_WEST:  x--;
          default:   y++;
        endcase
        ant_x[i]   = x;
        ant_y[i]   = y;
        ant_dir[i] = d;
      end
    endfunction

    function string fmt(ant_result_t r);
      return $sformatf("kind %0d idx %0d x %0d y %0d alive %0d dir %0d last %0d",
                       r.kind, r.idx, r.x, r.y, r.alive, r.dir, r.last);
    endfunction

    function void check_result(ant_result_t got);
      ant_result_t exp;
      if (pending.size() == 0) begin
        if (n_errors < REPORT_MAX)
          $display("%0t: result with none pending: %s", $time, fmt(got));
        n_errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        if (n_errors < REPORT_MAX)
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, fmt(exp),
                   fmt(got));
        n_errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       func_i = 1'b0;
  logic [7:0] start_x_i = '0;
  logic [7:0] start_y_i = '0;
  logic [1:0] start_dir_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [3:0] ant_index_o;
  logic [7:0] cell_x_o;
  logic [7:0] cell_y_o;
  logic       cell_alive_o;
  logic [1:0] new_dir_o;
  logic       last_o;

  walk_scoreboard walk_board = new();
  bit             no_gaps;
  int             idle_cycles;

  multi_ant_grid_walker_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_dir_i  (start_dir_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .ant_index_o  (ant_index_o),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_alive_o (cell_alive_o),
    .new_dir_o    (new_dir_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog: the clear sweep after reset is the longest quiet stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random back-pressure, one check per accepted result
  initial begin
    ant_result_t got;
    int          stall;
    wait (rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.kind  = kind_e'(kind_o);
      got.idx   = ant_index_o;
      got.x     = cell_x_o;
      got.y     = cell_y_o;
      got.alive = cell_alive_o;
      got.dir   = dir_e'(new_dir_o);
      got.last  = last_o;
      walk_board.check_result(got);
    end
  end

  // valid stays up after acceptance so back-to-back requests need no gap
  task automatic send_request(input func_e f, input logic [7:0] sx,
                              input logic [7:0] sy, input dir_e sd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i      = f;
    start_x_i   = sx;
    start_y_i   = sy;
    start_dir_i = sd;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    walk_board.note_request(f, sx, sy, sd);
  endtask

  task automatic tick();
    send_request(FUNC_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 dir_e'($urandom_range(0, 3)));
  endtask

  // drop valid, let every pending result drain, then allow the core to go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (walk_board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] index, input logic [8:0] data);
    @(negedge clk_i);
    cfg_index_i = index;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    walk_board.set_size(index, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [8:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd2;
      3:       return 9'd255;
      4:       return 9'd256;
      5:       return 9'($urandom_range(257, 511));
      6:       return 9'd511;
      default: return 9'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [7:0] pick_coord(int size);
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, size - 1));
  endfunction

  initial begin
    func_e f;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty tick, corner ants, and ants set to cross each edge
    cfg_write(REG_GRID_WIDTH, 9'd256);
    cfg_write(REG_GRID_HEIGHT, 9'd256);
    tick();
    send_request(FUNC_ADD, 8'd0,   8'd0,   DIR_NORTH);
    send_request(FUNC_ADD, 8'd255, 8'd255, DIR_SOUTH);
    send_request(FUNC_ADD, 8'd10,  8'd0,   DIR_WEST);
    send_request(FUNC_ADD, 8'd255, 8'd10,  DIR_NORTH);
    send_request(FUNC_ADD, 8'd0,   8'd20,  DIR_SOUTH);
    send_request(FUNC_ADD, 8'd30,  8'd255, DIR_EAST);
    repeat (4) tick();
    settle();
    // zero size behaves as one: every ant lands on the same cell
    cfg_write(REG_GRID_WIDTH, 9'd0);
    cfg_write(REG_GRID_HEIGHT, 9'd1);
    repeat (3) tick();
    settle();
    cfg_write(REG_GRID_WIDTH, 9'd511);
    cfg_write(REG_GRID_HEIGHT, 9'd256);
    send_request(FUNC_ADD, 8'd128, 8'd127, DIR_EAST);
    repeat (2) tick();
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      cfg_write(REG_GRID_WIDTH, pick_size());
      cfg_write(REG_GRID_HEIGHT, pick_size());
      if (phase == 2) begin
        cfg_write(REG_SPARE_2, 9'($urandom_range(0, 511)));
        cfg_write(REG_SPARE_3, 9'($urandom_range(0, 511)));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 50; n++) begin
        f = ($urandom_range(0, 99) < 30) ? FUNC_ADD : FUNC_TICK;
        send_request(f, pick_coord(walk_board.cols()), pick_coord(walk_board.rows()),
                     dir_e'($urandom_range(0, 3)));
      end
      settle();
      no_gaps = 1'b0;
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (walk_board.n_errors == 0 && walk_board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> multi_ant_grid_walker_core.f
+incdir+src
src/mag_pkg.sv
src/mag_ants.sv
src/mag_grid.sv
src/mag_seq.sv
src/multi_ant_grid_walker_core.sv
test/multi_ant_grid_walker_core_tb.sv
